[rtl/core/brpi_pkg.sv]
`timescale 1ns / 1ps

package brpi_pkg;

  localparam int NORM_W     = 16;
  localparam int DIR_W      = 16;
  localparam int OFFSET_W   = 42;
  localparam int EXT_BITS   = 21;
  localparam int HALF_W     = 3 * EXT_BITS;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_OFFSET   = 3'd3,
    CFG_CENTER_X = 3'd4,
    CFG_CENTER_Y = 3'd5,
    CFG_CENTER_Z = 3'd6,
    CFG_HALF_EXT = 3'd7
  } cfg_idx_e;

  localparam logic signed [NORM_W-1:0] NORMAL_Y_RST = 16'sd16384;

endpackage

[rtl/core/bounded_ray_plane_intersect.sv]
`timescale 1ns / 1ps

// bounded ray / plane intersection test
// request channel: in_valid_i / in_ready_o carry one ray (origin Q15.8, direction Q1.14)
// result channel: out_valid_o / out_ready_i carry hit_o and the hit point hit_x/y/z_o;
// the coordinates read zero whenever hit_o is low
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (normal x/y/z, plane offset, center x/y/z, packed half extents); write only while idle
// throughput: one request per cycle unless a stalled out_ready_i backs the pipe up; the
// depth is set by the restoring divider, which retires one quotient bit per stage for
// COORD_WIDTH + 1 stages on all three axes
// each stage holds a valid bit and moves on when the stage after it is empty or moving,
// so a stalled receiver fills the bubbles first and only then pulls in_ready_o low
// reset empties the pipe and loads the plane registers with normal (0, 1, 0), all else zero
module bounded_ray_plane_intersect #(
  parameter int COORD_WIDTH = 24,
  parameter int EPSILON     = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brpi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [brpi_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]     origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]     origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]     origin_z_i,
  input  logic signed [brpi_pkg::DIR_W-1:0] dir_x_i,
  input  logic signed [brpi_pkg::DIR_W-1:0] dir_y_i,
  input  logic signed [brpi_pkg::DIR_W-1:0] dir_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [COORD_WIDTH-1:0]     hit_x_o,
  output logic signed [COORD_WIDTH-1:0]     hit_y_o,
  output logic signed [COORD_WIDTH-1:0]     hit_z_o
);
  import brpi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int PRW  = CW + NORM_W;                // origin * normal
  localparam int DPW  = DIR_W + NORM_W;             // direction * normal
  localparam int DSW  = ((CW + NORM_W + 2) > OFFSET_W ? (CW + NORM_W + 2) : OFFSET_W) + 1;
  localparam int CSW  = DPW + 1;                    // cosine
  localparam int MDW  = DSW;                        // |distance|
  localparam int SPL  = 24;                         // split point of |distance|
  localparam int MHW  = MDW - SPL;
  localparam int NW   = MDW + DIR_W;                // dividend |dist| * |dir|
  localparam int QW   = CW + 1;                     // quotient bits
  localparam int HQW  = NW - QW;
  localparam int LMW  = (CW + 1) > EXT_BITS ? (CW + 1) : EXT_BITS;
  localparam int ST_D0 = 5;
  localparam int ST_R  = 6 + QW;
  localparam int ST_O  = 7 + QW;
  localparam int NS    = 8 + QW;

  localparam logic signed [DSW-1:0] EPS_D = DSW'(EPSILON);
  localparam logic signed [CSW-1:0] EPS_C = CSW'(EPSILON);

  typedef struct packed {
    logic                   ok;
    logic [CSW-1:0]         mc;
    logic [2:0]             neg;
    logic [2:0][CW-1:0]     org;
    logic [2:0][CSW-1:0]    rem;
    logic [2:0][QW-1:0]     nl;
    logic [2:0][QW-1:0]     quot;
  } div_t;

  // plane registers
  logic signed [NORM_W-1:0]   nrm_q [3];
  logic signed [OFFSET_W-1:0] off_q;
  logic signed [CW-1:0]       ctr_q [3];
  logic [HALF_W-1:0]          hext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= NORMAL_Y_RST;
      nrm_q[2] <= '0;
      off_q    <= '0;
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      hext_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL_X: nrm_q[0] <= cfg_wdata_i[NORM_W-1:0];
        CFG_NORMAL_Y: nrm_q[1] <= cfg_wdata_i[NORM_W-1:0];
        CFG_NORMAL_Z: nrm_q[2] <= cfg_wdata_i[NORM_W-1:0];
        CFG_OFFSET:   off_q    <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_CENTER_X: ctr_q[0] <= cfg_wdata_i[CW-1:0];
        CFG_CENTER_Y: ctr_q[1] <= cfg_wdata_i[CW-1:0];
        CFG_CENTER_Z: ctr_q[2] <= cfg_wdata_i[CW-1:0];
        CFG_HALF_EXT: hext_q   <= cfg_wdata_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage valid bits and bubble-collapsing advance
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o = en[0];

  logic signed [CW-1:0]    org [3];
  logic signed [DIR_W-1:0] dir [3];

  always_comb begin
    org[0] = origin_x_i;
    org[1] = origin_y_i;
    org[2] = origin_z_i;
    dir[0] = dir_x_i;
    dir[1] = dir_y_i;
    dir[2] = dir_z_i;
  end

  // stage 0: the six products
  logic signed [PRW-1:0]   po0_q [3];
  logic signed [DPW-1:0]   pd0_q [3];
  logic signed [CW-1:0]    o0_q  [3];
  logic signed [DIR_W-1:0] d0_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        po0_q[i] <= org[i] * nrm_q[i];
        pd0_q[i] <= dir[i] * nrm_q[i];
        o0_q[i]  <= org[i];
        d0_q[i]  <= dir[i];
      end
    end
  end

  // stage 1: distance and cosine
  logic signed [DSW-1:0]   dist1_q;
  logic signed [CSW-1:0]   cs1_q;
  logic signed [CW-1:0]    o1_q [3];
  logic signed [DIR_W-1:0] d1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dist1_q <= DSW'(po0_q[0]) + DSW'(po0_q[1]) + DSW'(po0_q[2]) + DSW'(off_q);
      cs1_q   <= CSW'(pd0_q[0]) + CSW'(pd0_q[1]) + CSW'(pd0_q[2]);
      o1_q    <= o0_q;
      d1_q    <= d0_q;
    end
  end

  // stage 2: facing test, magnitudes and result signs
  logic               ok2_d;
  logic               ok2_q;
  logic [MDW-1:0]     md2_q;
  logic [CSW-1:0]     mc2_q;
  logic [DIR_W-1:0]   mdir2_q [3];
  logic [2:0]         neg2_q;
  logic signed [CW-1:0] o2_q [3];

  assign ok2_d = !((dist1_q > EPS_D && cs1_q > EPS_C) ||
                   (dist1_q < EPS_D && cs1_q < EPS_C) || cs1_q == '0);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ok2_q <= ok2_d;
      md2_q <= dist1_q[DSW-1] ? MDW'(MDW'(0) - $unsigned(dist1_q)) : $unsigned(dist1_q);
      mc2_q <= cs1_q[CSW-1] ? CSW'(CSW'(0) - $unsigned(cs1_q)) : $unsigned(cs1_q);
      for (int i = 0; i < 3; i++) begin
        mdir2_q[i] <= d1_q[i][DIR_W-1] ? DIR_W'(DIR_W'(0) - $unsigned(d1_q[i]))
                                       : $unsigned(d1_q[i]);
        neg2_q[i]  <= !(dist1_q[DSW-1] ^ d1_q[i][DIR_W-1] ^ cs1_q[CSW-1]);
      end
      o2_q <= o1_q;
    end
  end

  // stage 3: partial products of |dist| * |dir|
  logic [SPL+DIR_W-1:0] pl3_q [3];
  logic [MHW+DIR_W-1:0] ph3_q [3];
  logic                 ok3_q;
  logic [CSW-1:0]       mc3_q;
  logic [2:0]           neg3_q;
  logic signed [CW-1:0] o3_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        pl3_q[i] <= md2_q[SPL-1:0] * mdir2_q[i];
        ph3_q[i] <= md2_q[MDW-1:SPL] * mdir2_q[i];
      end
      ok3_q  <= ok2_q;
      mc3_q  <= mc2_q;
      neg3_q <= neg2_q;
      o3_q   <= o2_q;
    end
  end

  // stage 4: dividends
  logic [NW-1:0]        n4_q [3];
  logic                 ok4_q;
  logic [CSW-1:0]       mc4_q;
  logic [2:0]           neg4_q;
  logic signed [CW-1:0] o4_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        n4_q[i] <= {ph3_q[i], {SPL{1'b0}}} + NW'(pl3_q[i]);
      end
      ok4_q  <= ok3_q;
      mc4_q  <= mc3_q;
      neg4_q <= neg3_q;
      o4_q   <= o3_q;
    end
  end

  // stage 5: quotient range check, divider start; then one quotient bit per stage
  div_t       div_q [QW+1];
  div_t       div0_d;
  logic [2:0] ovf;

  always_comb begin
    div0_d = '0;
    for (int i = 0; i < 3; i++) begin
      ovf[i]          = n4_q[i][NW-1:QW] >= HQW'(mc4_q);
      div0_d.rem[i]   = n4_q[i][QW+CSW-1:QW];
      div0_d.nl[i]    = n4_q[i][QW-1:0];
      div0_d.org[i]   = o4_q[i];
    end
    div0_d.ok  = ok4_q && !(|ovf);
    div0_d.mc  = mc4_q;
    div0_d.neg = neg4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_D0]) div_q[0] <= div0_d;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    div_t           nxt;
    logic [CSW:0]   trial [3];

    always_comb begin
      nxt = div_q[j];
      for (int i = 0; i < 3; i++) begin
        trial[i]   = {div_q[j].rem[i], div_q[j].nl[i][QW-1]};
        nxt.nl[i]  = {div_q[j].nl[i][QW-2:0], 1'b0};
        if (trial[i] >= {1'b0, div_q[j].mc}) begin
          nxt.rem[i]  = CSW'(trial[i] - {1'b0, div_q[j].mc});
          nxt.quot[i] = {div_q[j].quot[i][QW-2:0], 1'b1};
        end else begin
          nxt.rem[i]  = trial[i][CSW-1:0];
          nxt.quot[i] = {div_q[j].quot[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_D0+1+j]) div_q[j+1] <= nxt;
    end
  end

  // round to nearest (ties away from zero), apply sign, form the hit point
  logic [QW:0]           qr   [3];
  logic signed [QW+1:0]  offv [3];
  logic signed [CW+3:0]  pv   [3];
  logic signed [CW+3:0]  pr_q [3];
  logic                  okr_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr[i]   = {1'b0, div_q[QW].quot[i]} +
                (QW+1)'({div_q[QW].rem[i], 1'b0} >= {1'b0, div_q[QW].mc});
      offv[i] = div_q[QW].neg[i] ? -$signed({1'b0, qr[i]}) : $signed({1'b0, qr[i]});
      pv[i]   = (CW+4)'($signed(div_q[QW].org[i])) + (CW+4)'(offv[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_R]) begin
      pr_q  <= pv;
      okr_q <= div_q[QW].ok;
    end
  end

  // range and extent checks into the output register
  logic [2:0]           inr;
  logic [2:0]           inb;
  logic signed [CW:0]   dif [3];
  logic [CW:0]          dmag [3];
  logic                 hit_d;
  logic                 hit_q;
  logic [CW-1:0]        hp_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inr[i]  = (&pr_q[i][CW+3:CW-1]) || !(|pr_q[i][CW+3:CW-1]);
      dif[i]  = (CW+1)'($signed(pr_q[i][CW-1:0])) - (CW+1)'(ctr_q[i]);
      dmag[i] = dif[i][CW] ? (CW+1)'((CW+1)'(0) - $unsigned(dif[i])) : $unsigned(dif[i]);
      inb[i]  = LMW'(dmag[i]) <= LMW'(hext_q[EXT_BITS*i +: EXT_BITS]);
    end
    hit_d = okr_q && (&inr) && (&inb);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_O]) begin
      hit_q <= hit_d;
      for (int i = 0; i < 3; i++) begin
        hp_q[i] <= hit_d ? pr_q[i][CW-1:0] : '0;
      end
    end
  end

  assign out_valid_o = vld_q[ST_O];
  assign hit_o       = hit_q;
  assign hit_x_o     = hp_q[0];
  assign hit_y_o     = hp_q[1];
  assign hit_z_o     = hp_q[2];

  // an empty output stage means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with the output stage empty");

  // an accepted request lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipe entry");

  // a zero cosine never survives the facing test
  a_zero_cos_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[2] && vld_q[1] && cs1_q == '0 |=> !ok2_q)
    else $error("zero cosine passed the facing test");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0)
    else $error("miss with nonzero point");

endmodule

[dv/bounded_ray_plane_intersect_tb.sv]
`timescale 1ns / 1ps

module bounded_ray_plane_intersect_tb;
  import brpi_pkg::*;

  localparam int COORD_W    = 24;
  localparam int EPS        = 1;
  // pipeline depth of the block is COORD_W + 9, padded a little
  localparam int SETTLE     = COORD_W + 20;
  localparam int STALL_MAX  = 14;
  localparam int IDLE_LIMIT = 4000;

  // one ray request
  typedef struct {
    logic signed [COORD_W-1:0] ox, oy, oz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
  } ray_t;

  // one hit response
  typedef struct {
    logic               hit;
    logic [COORD_W-1:0] px, py, pz;
  } hit_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic signed [COORD_W-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [DIR_W-1:0]   dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   hit_o;
  logic signed [COORD_W-1:0] hit_x_o, hit_y_o, hit_z_o;

  bounded_ray_plane_intersect #(
    .COORD_WIDTH(COORD_W),
    .EPSILON    (EPS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .hit_x_o    (hit_x_o),
    .hit_y_o    (hit_y_o),
    .hit_z_o    (hit_z_o)
  );

  // shadow copy of the plane registers, reset values included
  longint          pl_nx = 0, pl_ny = longint'(NORMAL_Y_RST), pl_nz = 0;
  longint          pl_off = 0;
  longint          pl_cx = 0, pl_cy = 0, pl_cz = 0;
  longint unsigned pl_half = 0;

  ray_t pending_rays[$];
  hit_t expected_hits[$];

  int  err_count = 0;
  int  idle_cycles = 0;
  int  in_gap = 0, out_wait = 0;
  int  rays_queued = 0, hits_seen = 0;
  bit  in_quiet = 1'b0, out_quiet = 1'b0;
  logic in_acc = 1'b0, out_acc = 1'b0;
  int  spread = 256;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned magnitude(longint v);
    return longint'(v < 0 ? -v : v);
  endfunction

  // rounded -sdist*dv/cs in units of 2^-8, ties away from zero; 0 on overflow
  function automatic bit step_offset(longint sdist, longint dv, longint cs,
                                     output longint res);
    longint unsigned md, mdv, mc, a, b, r2, q;
    bit neg;
    md  = magnitude(sdist);
    mdv = magnitude(dv);
    mc  = magnitude(cs);
    res = 0;
    if (mdv == 0 || md == 0) return 1'b1;
    a = md / mc;
    b = md % mc;
    if (a >= (64'd1 << 40)) return 1'b0;
    r2 = b * mdv;
    q  = a * mdv + r2 / mc;
    if (2 * (r2 % mc) >= mc) q++;
    neg = !((sdist < 0) ^ (dv < 0) ^ (cs < 0));
    res = neg ? -longint'(q) : longint'(q);
    return 1'b1;
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    longint o[3], d[3], c[3], p[3];
    longint sdist, cs, off, lo, hi;
    longint unsigned lim;
    bit ok;
    hit_t h;
    o[0] = longint'(r.ox); o[1] = longint'(r.oy); o[2] = longint'(r.oz);
    d[0] = longint'(r.dx); d[1] = longint'(r.dy); d[2] = longint'(r.dz);
    c[0] = pl_cx; c[1] = pl_cy; c[2] = pl_cz;
    p[0] = 0; p[1] = 0; p[2] = 0;
    sdist = o[0] * pl_nx + o[1] * pl_ny + o[2] * pl_nz + pl_off;
    cs    = d[0] * pl_nx + d[1] * pl_ny + d[2] * pl_nz;
    // facing away from the plane on both terms, or parallel to it
    ok = !((sdist > EPS && cs > EPS) || (sdist < EPS && cs < EPS) || cs == 0);
    lo = -(longint'(1) <<< (COORD_W - 1));
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      if (ok) begin
        lim = (pl_half >> (EXT_BITS * i)) & ((64'd1 << EXT_BITS) - 1);
        if (!step_offset(sdist, d[i], cs, off)) begin
          ok = 1'b0;
        end else begin
          p[i] = o[i] + off;
          if (p[i] < lo || p[i] > hi) ok = 1'b0;
          else if (magnitude(p[i] - c[i]) > lim) ok = 1'b0;
        end
      end
    end
    h.hit = ok;
    h.px  = ok ? p[0][COORD_W-1:0] : '0;
    h.py  = ok ? p[1][COORD_W-1:0] : '0;
    h.pz  = ok ? p[2][COORD_W-1:0] : '0;
    return h;
  endfunction

  // append one ray to the driver queue
  task automatic queue_ray(ray_t r);
    pending_rays.insert(pending_rays.size(), r);
    rays_queued++;
  endtask

  // register write; junk above the register width must be dropped by the block
  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_NORMAL_X: pl_nx   = longint'($signed(data[NORM_W-1:0]));
      CFG_NORMAL_Y: pl_ny   = longint'($signed(data[NORM_W-1:0]));
      CFG_NORMAL_Z: pl_nz   = longint'($signed(data[NORM_W-1:0]));
      CFG_OFFSET:   pl_off  = longint'($signed(data[OFFSET_W-1:0]));
      CFG_CENTER_X: pl_cx   = longint'($signed(data[COORD_W-1:0]));
      CFG_CENTER_Y: pl_cy   = longint'($signed(data[COORD_W-1:0]));
      CFG_CENTER_Z: pl_cz   = longint'($signed(data[COORD_W-1:0]));
      CFG_HALF_EXT: pl_half = longint'(data[HALF_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] junk_above(int w, longint v);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'({$urandom, $urandom});
    for (int i = 0; i < w; i++) r[i] = v[i];
    return r;
  endfunction

  // plane for one random phase: normal, center, offset, extents
  task automatic plane_setup(int ph);
    longint nx, ny, nz, cx, cy, cz, off;
    longint unsigned half;
    int lb;
    case (ph % 4)
      0: begin
        nx = 0; ny = 0; nz = 0;
        case ($urandom_range(0, 2))
          0: nx = $urandom_range(0, 1) ? 16384 : -16384;
          1: ny = $urandom_range(0, 1) ? 16384 : -16384;
          default: nz = $urandom_range(0, 1) ? 16384 : -16384;
        endcase
      end
      2: begin
        nx = 32767; ny = -32768; nz = $urandom_range(0, 1) ? 32767 : -32768;
      end
      default: begin
        nx = longint'($signed(16'($urandom)));
        ny = longint'($signed(16'($urandom)));
        nz = longint'($signed(16'($urandom)));
      end
    endcase
    if (ph % 4 == 2) begin
      cx = 8388607; cy = -8388608; cz = $urandom_range(0, 1) ? 8388607 : -8388608;
    end else begin
      cx = longint'($urandom_range(0, 2097152)) - 1048576;
      cy = longint'($urandom_range(0, 2097152)) - 1048576;
      cz = longint'($urandom_range(0, 2097152)) - 1048576;
    end
    off = -(nx * cx + ny * cy + nz * cz);
    // a shifted plane with a fully random offset in one phase kind
    if (ph % 4 == 3) off = longint'($signed(42'({$urandom, $urandom})));
    lb = $urandom_range(6, 16);
    spread = 1 << lb;
    case (ph % 3)
      1: half = 64'h7fff_ffff_ffff_ffff;
      default: half = 64'({21'($urandom_range(0, 2 * spread)),
                           21'($urandom_range(0, 2 * spread)),
                           21'($urandom_range(0, 2 * spread))});
    endcase
    if (ph == 5) half = 0;
    half = half & 64'h7fff_ffff_ffff_ffff;
    cfg_write(CFG_NORMAL_X, junk_above(NORM_W, nx));
    cfg_write(CFG_NORMAL_Y, junk_above(NORM_W, ny));
    cfg_write(CFG_NORMAL_Z, junk_above(NORM_W, nz));
    cfg_write(CFG_OFFSET,   junk_above(OFFSET_W, off));
    cfg_write(CFG_CENTER_X, junk_above(COORD_W, cx));
    cfg_write(CFG_CENTER_Y, junk_above(COORD_W, cy));
    cfg_write(CFG_CENTER_Z, junk_above(COORD_W, cz));
    cfg_write(CFG_HALF_EXT, CFG_DATA_W'(half));
  endtask

  function automatic logic signed [DIR_W-1:0] rand_dir();
    // short directions give long travel and push the hit point out of range
    if ($urandom_range(0, 3) == 0) return DIR_W'($urandom_range(0, 64)) - 16'sd32;
    return DIR_W'($urandom);
  endfunction

  // mostly rays that start near the plane center, the rest pure noise
  function automatic ray_t rand_ray();
    ray_t r;
    if ($urandom_range(0, 3) == 0) begin
      r.ox = COORD_W'($urandom); r.oy = COORD_W'($urandom); r.oz = COORD_W'($urandom);
      r.dx = DIR_W'($urandom);   r.dy = DIR_W'($urandom);   r.dz = DIR_W'($urandom);
    end else begin
      r.ox = COORD_W'(pl_cx + longint'($urandom_range(0, 4 * spread)) - 2 * spread);
      r.oy = COORD_W'(pl_cy + longint'($urandom_range(0, 4 * spread)) - 2 * spread);
      r.oz = COORD_W'(pl_cz + longint'($urandom_range(0, 4 * spread)) - 2 * spread);
      r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    end
    return r;
  endfunction

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = COORD_W'(ox); r.oy = COORD_W'(oy); r.oz = COORD_W'(oz);
    r.dx = DIR_W'(dx);   r.dy = DIR_W'(dy);   r.dz = DIR_W'(dz);
    return r;
  endfunction

  // block is idle once every queued request has come back, then let the pipe settle
  task automatic drain();
    while (hits_seen != rays_queued)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // request driver: holds valid and payload until the request is taken
  always @(negedge clk_i) begin : ray_driver
    logic nv;
    ray_t r;
    if (rst_ni) begin
      nv = in_valid_i && !in_acc;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_rays.size() > 0) begin
          r = pending_rays.pop_front();
          origin_x_i <= r.ox; origin_y_i <= r.oy; origin_z_i <= r.oz;
          dir_x_i    <= r.dx; dir_y_i    <= r.dy; dir_z_i    <= r.dz;
          nv = 1'b1;
          in_gap = draw_gap(in_quiet);
        end
      end
      in_valid_i <= nv;
    end
  end

  // response side back-pressure, one wait drawn per accepted response
  always @(negedge clk_i) begin : hit_sink
    logic nr;
    if (rst_ni) begin
      if (out_acc) out_wait = draw_gap(out_quiet);
      if (out_wait > 0) begin
        nr = 1'b0;
        out_wait--;
      end else begin
        nr = 1'b1;
      end
      out_ready_i <= nr;
    end
  end

  task automatic check_coord(string name, logic [COORD_W-1:0] e, logic [COORD_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $realtime, name, e, a);
      err_count++;
    end
  endtask

  // sample both channels at the rising edge, predict on requests, check on responses
  always @(posedge clk_i) begin : hit_monitor
    ray_t r;
    hit_t e;
    logic in_fire, out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    in_acc  <= in_fire;
    out_acc <= out_fire;
    if (in_fire) begin
      r.ox = origin_x_i; r.oy = origin_y_i; r.oz = origin_z_i;
      r.dx = dir_x_i;    r.dy = dir_y_i;    r.dz = dir_z_i;
      expected_hits.insert(expected_hits.size(), predict_hit(r));
    end
    if (out_fire) begin
      hits_seen++;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected response expected none actual hit=%b %h %h %h",
                 $realtime, hit_o, hit_x_o, hit_y_o, hit_z_o);
        err_count++;
      end else begin
        e = expected_hits.pop_front();
        if (e.hit !== hit_o) begin
          $display("%0t: hit mismatch expected %b actual %b", $realtime, e.hit, hit_o);
          err_count++;
        end
        check_coord("hit_x", e.px, hit_x_o);
        check_coord("hit_y", e.py, hit_y_o);
        check_coord("hit_z", e.pz, hit_z_o);
      end
    end
    // watchdog on cycles with no traffic on either channel
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset plane: y normal through the origin, zero extents, only exact hits
    queue_ray(mk_ray(0, 256, 0, 0, -16384, 0));
    queue_ray(mk_ray(0, 256, 0, 0, 16384, 0));
    queue_ray(mk_ray(8388607, 8388607, 8388607, 32767, 32767, 32767));
    queue_ray(mk_ray(-8388608, -8388608, -8388608,
                     -32768, -32768, -32768));
    queue_ray(mk_ray(0, -8388608, 0, 32767, 32767, -32768));
    // parallel to the plane, zero cosine
    queue_ray(mk_ray(100, 512, -100, 16384, 0, -16384));
    queue_ray(mk_ray(0, 0, 0, 0, 0, 0));
    drain();

    // z plane at center (1000, -2000, 3000) with x extent 256 and y extent 512
    cfg_write(CFG_NORMAL_X, '0);
    cfg_write(CFG_NORMAL_Y, '0);
    cfg_write(CFG_NORMAL_Z, CFG_DATA_W'(16384));
    cfg_write(CFG_OFFSET,   junk_above(OFFSET_W, -longint'(16384) * 3000));
    cfg_write(CFG_CENTER_X, CFG_DATA_W'(1000));
    cfg_write(CFG_CENTER_Y, junk_above(COORD_W, -2000));
    cfg_write(CFG_CENTER_Z, CFG_DATA_W'(3000));
    cfg_write(CFG_HALF_EXT, {21'd0, 21'd512, 21'd256});
    // exactly on the x limit, then one step outside it
    queue_ray(mk_ray(1256, -2000, 3256, 0, 0, -16384));
    queue_ray(mk_ray(1257, -2000, 3256, 0, 0, -16384));
    queue_ray(mk_ray(744, -2512, 2744, 0, 0, 16384));
    queue_ray(mk_ray(1000, -2000, 3001, 0, 0, -16384));
    queue_ray(mk_ray(1000, -1000, 3500, 3, -5, -7));
    drain();

    // plane shifted so that the distance lands right on the tolerance
    cfg_write(CFG_NORMAL_Z, CFG_DATA_W'(1));
    cfg_write(CFG_OFFSET,   CFG_DATA_W'(1));
    cfg_write(CFG_CENTER_X, '0);
    cfg_write(CFG_CENTER_Y, '0);
    cfg_write(CFG_CENTER_Z, '0);
    cfg_write(CFG_HALF_EXT, CFG_DATA_W'(64'h7fff_ffff_ffff_ffff));
    queue_ray(mk_ray(0, 0, 0, 0, 0, -1));
    queue_ray(mk_ray(0, 0, 0, 0, 0, 1));
    queue_ray(mk_ray(5, -5, 0, 32767, -32768, -1));
    queue_ray(mk_ray(0, 0, -2, 0, 0, 1));
    // hit point far out of the coordinate range
    queue_ray(mk_ray(0, 0, -8388608, 32767, 0, 1));
    queue_ray(mk_ray(0, 0, 8388607, -32768, 0, -1));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      plane_setup(ph);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 200; n++) queue_ray(rand_ray());
      drain();
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
